@@ rtl/simplex_noise_2d_defines.svh @@
// assertion macros for the simplex noise block
`ifndef SIMPLEX_NOISE_2D_DEFINES_SVH
`define SIMPLEX_NOISE_2D_DEFINES_SVH

`ifndef SYNTHESIS
`define SND_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SND_ASSERT_NEVER(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("assertion failed");
`else
`define SND_ASSERT_IMPL(name, ante, cons)
`define SND_ASSERT_NEVER(name, expr)
`endif

`endif

@@ rtl/snd_pkg.sv @@
package snd_pkg;

	localparam logic [30:0] SKEW_Q32   = 31'd1572067139;
	localparam logic [29:0] UNSKEW_Q32 = 30'd907633386;
	localparam logic signed [17:0] OUT_MAX = 18'sd131071;
	localparam logic signed [17:0] OUT_MIN = -18'sd131072;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	// sign of one gradient component
	typedef enum logic [1:0] {
		G_ZERO,
		G_POS,
		G_NEG
	} gsign_t;

	// h mod 12 by reciprocal, exact for 8-bit h
	function automatic logic [3:0] mod12(input logic [7:0] h);
		logic [15:0] p;
		logic [7:0] q;
		logic [7:0] r;
		p = 16'(h) * 16'd171;
		q = {3'b000, p[15:11]};
		r = h - 8'(q * 8'd12);
		return r[3:0];
	endfunction

	function automatic gsign_t grad_x(input logic [3:0] r);
		gsign_t g;
		unique case (r)
			4'd0, 4'd2, 4'd4, 4'd6: g = G_POS;
			4'd1, 4'd3, 4'd5, 4'd7: g = G_NEG;
			default:                g = G_ZERO;
		endcase
		return g;
	endfunction

	function automatic gsign_t grad_y(input logic [3:0] r);
		gsign_t g;
		unique case (r)
			4'd0, 4'd1, 4'd8, 4'd10: g = G_POS;
			4'd2, 4'd3, 4'd9, 4'd11: g = G_NEG;
			default:                 g = G_ZERO;
		endcase
		return g;
	endfunction

endpackage

@@ rtl/snd_perm_ram.sv @@
module snd_perm_ram (
	input  logic       clk,
	input  logic       we,
	input  logic [7:0] waddr,
	input  logic [7:0] wdata,
	input  logic [7:0] raddr_a,
	output logic [7:0] rdata_a,
	input  logic [7:0] raddr_b,
	output logic [7:0] rdata_b
);

	logic [7:0] mem [256];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

@@ rtl/snd_corner.sv @@
module snd_corner #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic signed [FRAC_BITS+2:0]          dx,
	input  logic signed [FRAC_BITS+2:0]          dy,
	input  logic [7:0]                           hash,
	output logic signed [2*FRAC_BITS+4:0]        contrib
);

	localparam int F  = FRAC_BITS;
	localparam int D  = F + 3;
	localparam int TW = 2 * D + 2;
	localparam int CW = F + D + 2;
	localparam logic signed [TW-1:0] HALF = TW'(1) << (2 * F - 1);

	logic signed [2*D-1:0] sq_x, sq_y;
	logic signed [TW-1:0]  t;
	logic [F-1:0]          t1_s6, t2_s7, t4_s8;
	logic                  pos_s6, pos_s7, pos_s8;
	logic signed [D-1:0]   dx_s6, dy_s6;
	logic signed [D:0]     dot_s7, dot_s8;
	logic signed [D:0]     part_x, part_y;
	logic [3:0]            gsel;
	snd_pkg::gsign_t       gx, gy;
	logic [2*F-1:0]        p2, p4;

	// falloff before the first power step
	assign sq_x = dx * dx;
	assign sq_y = dy * dy;
	assign t    = HALF - TW'(sq_x) - TW'(sq_y);

	// gradient from the hash, dot with the offset
	assign gsel = snd_pkg::mod12(hash);
	assign gx   = snd_pkg::grad_x(gsel);
	assign gy   = snd_pkg::grad_y(gsel);

	always_comb begin
		unique case (gx)
			snd_pkg::G_POS: part_x = (D+1)'(dx_s6);
			snd_pkg::G_NEG: part_x = -(D+1)'(dx_s6);
			default:        part_x = '0;
		endcase
		unique case (gy)
			snd_pkg::G_POS: part_y = (D+1)'(dy_s6);
			snd_pkg::G_NEG: part_y = -(D+1)'(dy_s6);
			default:        part_y = '0;
		endcase
	end

	assign p2 = t1_s6 * t1_s6;
	assign p4 = t2_s7 * t2_s7;

	always_ff @(posedge clk) begin
		t1_s6   <= t[2*F-1:F];
		pos_s6  <= ~t[TW-1];
		dx_s6   <= dx;
		dy_s6   <= dy;
		t2_s7   <= p2[2*F-1:F];
		dot_s7  <= part_x + part_y;
		pos_s7  <= pos_s6;
		t4_s8   <= p4[2*F-1:F];
		dot_s8  <= dot_s7;
		pos_s8  <= pos_s7;
		contrib <= pos_s8 ? CW'($signed({1'b0, t4_s8}) * dot_s8) : '0;
	end

endmodule

@@ rtl/simplex_noise_2d.sv @@
// throughput: one evaluate or one load per cycle; a load waits while an evaluate is still
// between acceptance and its second table read
// reset: arst_n clears all valid flags at once; the table holds whatever was loaded
// the receiver cannot stall: done lasts exactly one cycle for each result
`include "simplex_noise_2d_defines.svh"

module simplex_noise_2d #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [7:0]         entry_index,
	input  logic [7:0]         entry_data,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	output logic               done,
	output logic signed [17:0] noise_out
);

	localparam int F  = FRAC_BITS;
	localparam int D  = F + 3;            // corner offsets, range about +-4
	localparam int IW = 34 - F;           // integer cell coordinate
	localparam int UW = IW + 32;          // unskew product
	localparam int CW = F + D + 2;        // one corner contribution
	localparam int SW = CW + 2;           // sum of three
	localparam int MW = SW + 7;           // sum times 70
	localparam longint G2F_L =
		(longint'(snd_pkg::UNSKEW_Q32) + (64'sd1 <<< (31 - F))) >>> (32 - F);
	localparam logic signed [D-1:0] ONE  = D'(64'sd1 <<< F);
	localparam logic signed [D-1:0] G2F  = D'(G2F_L);
	localparam logic signed [D-1:0] G2F2 = D'(2 * G2F_L);
	localparam logic signed [MW-1:0] RND = MW'(1) << (F - 1);

	// request handshake
	logic accept, load_req, eval_req;
	logic [10:1] v_q;                      // v_q[k] marks a live evaluate in stage k

	// a load is held off while an evaluate still has a table read ahead of it
	assign busy     = start & (kind == snd_pkg::KIND_LOAD) & (|v_q[4:1]);
	assign accept   = start & ~busy;
	assign load_req = accept & (kind == snd_pkg::KIND_LOAD);
	assign eval_req = accept & (kind == snd_pkg::KIND_EVAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q  <= '0;
			done <= 1'b0;
		end else begin
			v_q  <= {v_q[9:1], eval_req};
			done <= v_q[10];
		end
	end

	// stage 1: skew product
	logic signed [31:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4;
	logic signed [32:0] xy_sum;
	logic signed [64:0] skew_prod, skew_prod_s2;

	assign xy_sum    = {x_s1[31], x_s1} + {y_s1[31], y_s1};
	assign skew_prod = xy_sum * $signed({1'b0, snd_pkg::SKEW_Q32});

	// stage 2: floor to the cell
	logic signed [32:0] skew;
	logic signed [33:0] xs, ys;
	logic signed [IW-1:0] i_s3, j_s3, i_s4, j_s4;

	assign skew = skew_prod_s2[64:32];
	assign xs   = {{2{x_s2[31]}}, x_s2} + {skew[32], skew};
	assign ys   = {{2{y_s2[31]}}, y_s2} + {skew[32], skew};

	// stage 3: unskew product
	logic signed [IW:0]   ij_sum;
	logic signed [UW-1:0] un_prod, un_prod_s4;

	assign ij_sum  = {i_s3[IW-1], i_s3} + {j_s3[IW-1], j_s3};
	assign un_prod = ij_sum * $signed({1'b0, snd_pkg::UNSKEW_Q32});

	// stage 4: corner offsets and first table reads
	logic signed [33:0]  un;
	logic signed [35:0]  x0w, y0w;
	logic signed [D-1:0] x0, y0;
	logic                sx;
	logic signed [D-1:0] dx_s5 [3];
	logic signed [D-1:0] dy_s5 [3];
	logic [7:0]          jj, ii_s5;
	logic                sx_s5;
	logic [7:0]          addr_a [3];
	logic [7:0]          addr_b [3];
	logic [7:0]          rd_a [3];
	logic [7:0]          rd_b [3];

	assign un  = un_prod_s4[UW-1:32-F];
	assign x0w = x_s4 - (i_s4 <<< F) + un;
	assign y0w = y_s4 - (j_s4 <<< F) + un;
	assign x0  = x0w[D-1:0];
	assign y0  = y0w[D-1:0];
	assign sx  = (x0 > y0);            // a tie takes the y step
	assign jj  = j_s4[7:0];

	assign addr_a[0] = jj;
	assign addr_a[1] = jj + {7'b0, ~sx};
	assign addr_a[2] = jj + 8'd1;

	// stage 5: second table reads
	assign addr_b[0] = ii_s5 + rd_a[0];
	assign addr_b[1] = ii_s5 + {7'b0, sx_s5} + rd_a[1];
	assign addr_b[2] = ii_s5 + 8'd1 + rd_a[2];

	always_ff @(posedge clk) begin
		x_s1         <= point_x;
		y_s1         <= point_y;
		skew_prod_s2 <= skew_prod;
		x_s2         <= x_s1;
		y_s2         <= y_s1;
		i_s3         <= xs[33:F];
		j_s3         <= ys[33:F];
		x_s3         <= x_s2;
		y_s3         <= y_s2;
		un_prod_s4   <= un_prod;
		i_s4         <= i_s3;
		j_s4         <= j_s3;
		x_s4         <= x_s3;
		y_s4         <= y_s3;
		dx_s5[0]     <= x0;
		dy_s5[0]     <= y0;
		dx_s5[1]     <= x0 - (sx ? ONE : '0) + G2F;
		dy_s5[1]     <= y0 - (sx ? '0 : ONE) + G2F;
		dx_s5[2]     <= x0 - ONE + G2F2;
		dy_s5[2]     <= y0 - ONE + G2F2;
		ii_s5        <= i_s4[7:0];
		sx_s5        <= sx;
	end

	// one table copy per corner, every load writes all three
	logic signed [CW-1:0] contrib [3];

	for (genvar k = 0; k < 3; k++) begin : g_corner
		snd_perm_ram u_ram (
			.clk     (clk),
			.we      (load_req),
			.waddr   (entry_index),
			.wdata   (entry_data),
			.raddr_a (addr_a[k]),
			.rdata_a (rd_a[k]),
			.raddr_b (addr_b[k]),
			.rdata_b (rd_b[k])
		);

		snd_corner #(
			.FRAC_BITS (FRAC_BITS)
		) u_corner (
			.clk     (clk),
			.dx      (dx_s5[k]),
			.dy      (dy_s5[k]),
			.hash    (rd_b[k]),
			.contrib (contrib[k])
		);
	end

	// sum, scale by 70, round half up, saturate
	logic signed [SW-1:0] sum_s10;
	logic signed [MW-1:0] sum_w, scaled;
	logic signed [MW-F-1:0] r;
	logic signed [17:0] sat;

	assign sum_w  = MW'(sum_s10);
	assign scaled = (sum_w <<< 6) + (sum_w <<< 2) + (sum_w <<< 1) + RND;
	assign r      = scaled[MW-1:F];

	always_comb begin
		priority if (r > (MW-F)'(snd_pkg::OUT_MAX)) begin
			sat = snd_pkg::OUT_MAX;
		end else if (r < (MW-F)'(snd_pkg::OUT_MIN)) begin
			sat = snd_pkg::OUT_MIN;
		end else begin
			sat = r[17:0];
		end
	end

	always_ff @(posedge clk) begin
		sum_s10   <= SW'(contrib[0]) + SW'(contrib[1]) + SW'(contrib[2]);
		noise_out <= sat;
	end

	`SND_ASSERT_IMPL(a_load_no_overtake, load_req, !(|v_q[4:1]))
	`SND_ASSERT_IMPL(a_done_from_eval, done, $past(eval_req, 11))
	`SND_ASSERT_IMPL(a_busy_only_load, busy, start && (kind == snd_pkg::KIND_LOAD))

endmodule
